### hdl/pwfs_pkg.sv
// ----------------------------------------------------------------------------
// pwfs_pkg
// Shared types and constants of the per-worker free buffer stack: payload
// structs, command and status codes, and the sizes of the stack memory.
// ----------------------------------------------------------------------------
package pwfs_pkg;

  // Pool geometry.
  localparam int MAX_WORKERS = 32;
  localparam int POOL_DEPTH  = 1024;

  // Derived widths.
  localparam int WORKER_W = $clog2(MAX_WORKERS);              // stack select
  localparam int IDX_W    = $clog2(POOL_DEPTH);               // entry in one stack
  localparam int ADDR_W   = WORKER_W + IDX_W;                 // stack memory address
  localparam int ACT_W    = $clog2(MAX_WORKERS + 1);          // active worker count
  localparam int TOP_W    = $clog2(POOL_DEPTH + 1);           // fill level of one stack
  localparam int OUT_W    = $clog2(MAX_WORKERS * POOL_DEPTH + 1); // buffers handed out

  // Field widths fixed by the interface.
  localparam int CMD_W    = 2;
  localparam int WID_W    = 6;
  localparam int HANDLE_W = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DEINIT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_FULL        = 3'd2,
    ST_BAD_WORKER  = 3'd3,
    ST_OUTSTANDING = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INIT,
    OP_DEINIT
  } op_t;

  // Request beat.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [WID_W-1:0]    worker;
    logic [HANDLE_W-1:0] buf_handle;
  } req_t;

  // Response beat.
  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] alloc_handle;
  } rsp_t;

  // Decoded command between front and back.
  typedef struct packed {
    op_t                 op;
    logic [WID_W-1:0]    worker;
    logic [HANDLE_W-1:0] buf_handle;
  } op_item_t;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic [5:0]  worker_count;
    logic [15:0] buf_size;
    logic [10:0] pool_count;
  } cfg_t;

endpackage

### hdl/pwfs_front.sv
// ----------------------------------------------------------------------------
// pwfs_front
// Request front end: accepts request beats, decodes the command into an
// operation and holds it in a register until the command queue takes it.
// ----------------------------------------------------------------------------
module pwfs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  pwfs_pkg::req_t     req,
  output logic               op_valid,
  input  logic               op_ready,
  output pwfs_pkg::op_item_t op_item
);

  pwfs_pkg::op_t op_dec;

  // The stage takes a beat when it is empty or is being drained.
  assign req_ready = !op_valid || op_ready;

  // Command decode.
  always_comb begin
    case (req.cmd)
      pwfs_pkg::CMD_ALLOC:  op_dec = pwfs_pkg::OP_ALLOC;
      pwfs_pkg::CMD_FREE:   op_dec = pwfs_pkg::OP_FREE;
      pwfs_pkg::CMD_INIT:   op_dec = pwfs_pkg::OP_INIT;
      pwfs_pkg::CMD_DEINIT: op_dec = pwfs_pkg::OP_DEINIT;
      default:              op_dec = pwfs_pkg::OP_ALLOC;
    endcase
  end

  // Output register of the front stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      op_valid           <= 1'b1;
      op_item.op         <= op_dec;
      op_item.worker     <= req.worker;
      op_item.buf_handle <= req.buf_handle;
    end else if (op_ready) begin
      op_valid <= 1'b0;
    end
  end

endmodule

### hdl/pwfs_queue.sv
// ----------------------------------------------------------------------------
// pwfs_queue
// Two-entry command queue between the front end and the back end, so that
// either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module pwfs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  pwfs_pkg::op_item_t wr_item,
  output logic               rd_valid,
  input  logic               rd_ready,
  output pwfs_pkg::op_item_t rd_item
);

  pwfs_pkg::op_item_t slots [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;
  logic               push;
  logic               pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

### hdl/pwfs_back.sv
// ----------------------------------------------------------------------------
// pwfs_back
// Execution back end: holds the stack memory, the per-worker fill levels and
// the pool state, carries out alloc, free, init and deinit, and keeps the
// response register.
// ----------------------------------------------------------------------------
module pwfs_back (
  input  logic               clk,
  input  logic               rst,
  input  pwfs_pkg::cfg_t     cfg,
  input  logic               op_valid,
  output logic               op_ready,
  input  pwfs_pkg::op_item_t op_item,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output pwfs_pkg::rsp_t     rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FILL
  } state_t;

  state_t state;

  // Stack memory: one region of POOL_DEPTH entries per worker.
  logic [pwfs_pkg::HANDLE_W-1:0] mem [pwfs_pkg::MAX_WORKERS * pwfs_pkg::POOL_DEPTH];
  logic [pwfs_pkg::HANDLE_W-1:0] rd_data;
  logic                          mem_we;
  logic                          mem_re;
  logic [pwfs_pkg::ADDR_W-1:0]   mem_waddr;
  logic [pwfs_pkg::ADDR_W-1:0]   mem_raddr;
  logic [pwfs_pkg::HANDLE_W-1:0] mem_wdata;

  // Pool state.
  logic [pwfs_pkg::TOP_W-1:0]    stack_top [pwfs_pkg::MAX_WORKERS];
  logic                          pool_ready;
  logic [pwfs_pkg::ACT_W-1:0]    active;
  logic [pwfs_pkg::TOP_W-1:0]    cap;
  logic [pwfs_pkg::OUT_W-1:0]    out_count;

  // Fill walk.
  logic [pwfs_pkg::WORKER_W-1:0] fw;
  logic [pwfs_pkg::IDX_W-1:0]    fi;
  logic [pwfs_pkg::HANDLE_W-1:0] off;

  logic                          take;
  logic                          bad;
  logic [pwfs_pkg::WORKER_W-1:0] w_idx;
  logic [pwfs_pkg::TOP_W-1:0]    top_cur;
  logic                          top_zero;
  logic                          top_full;
  logic [pwfs_pkg::ACT_W-1:0]    nw_sat;
  logic [pwfs_pkg::TOP_W-1:0]    cap_sat;
  logic                          last_i;
  logic                          last_w;

  // A command is taken in idle once the response register is free.
  assign op_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign take     = op_ready && op_valid;

  // Classification against the current pool state.
  assign w_idx    = op_item.worker[pwfs_pkg::WORKER_W-1:0];
  assign bad      = (7'(op_item.worker) >= 7'(active));
  assign top_cur  = stack_top[w_idx];
  assign top_zero = (top_cur == '0);
  assign top_full = (top_cur >= cap);

  // Saturated init geometry.
  assign nw_sat  = (7'(cfg.worker_count) > 7'(pwfs_pkg::MAX_WORKERS)) ?
                   pwfs_pkg::ACT_W'(pwfs_pkg::MAX_WORKERS) :
                   pwfs_pkg::ACT_W'(cfg.worker_count);
  assign cap_sat = (17'(cfg.pool_count) > 17'(pwfs_pkg::POOL_DEPTH)) ?
                   pwfs_pkg::TOP_W'(pwfs_pkg::POOL_DEPTH) :
                   pwfs_pkg::TOP_W'(cfg.pool_count);

  // End of one stack and of the whole fill walk.
  assign last_i = ((pwfs_pkg::TOP_W'(fi) + pwfs_pkg::TOP_W'(1)) == cap);
  assign last_w = ((pwfs_pkg::ACT_W'(fw) + pwfs_pkg::ACT_W'(1)) == active);

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {w_idx, top_cur[pwfs_pkg::IDX_W-1:0]};
    mem_wdata = op_item.buf_handle;
    mem_raddr = {w_idx, pwfs_pkg::IDX_W'(top_cur - pwfs_pkg::TOP_W'(1))};
    if (state == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = {fw, fi};
      mem_wdata = off;
    end else if (take && !bad) begin
      if (op_item.op == pwfs_pkg::OP_ALLOC && !top_zero) begin
        mem_re = 1'b1;
      end
      if (op_item.op == pwfs_pkg::OP_FREE && !top_full) begin
        mem_we = 1'b1;
      end
    end
  end

  // Stack memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Sequencer, pool state and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      pool_ready <= 1'b0;
      active     <= '0;
      cap        <= '0;
      out_count  <= '0;
      for (int i = 0; i < pwfs_pkg::MAX_WORKERS; i++) begin
        stack_top[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            rsp.alloc_handle <= '0;
            rsp.status       <= pwfs_pkg::ST_OK;
            rsp_valid        <= 1'b1;
            case (op_item.op)
              pwfs_pkg::OP_ALLOC: begin
                if (bad) begin
                  rsp.status <= pwfs_pkg::ST_BAD_WORKER;
                end else if (top_zero) begin
                  rsp.status <= pwfs_pkg::ST_EMPTY;
                end else begin
                  // The popped entry arrives from memory next cycle.
                  rsp_valid        <= 1'b0;
                  stack_top[w_idx] <= top_cur - pwfs_pkg::TOP_W'(1);
                  out_count        <= out_count + pwfs_pkg::OUT_W'(1);
                  state            <= S_READ;
                end
              end
              pwfs_pkg::OP_FREE: begin
                if (bad) begin
                  rsp.status <= pwfs_pkg::ST_BAD_WORKER;
                end else if (top_full) begin
                  rsp.status <= pwfs_pkg::ST_FULL;
                end else begin
                  stack_top[w_idx] <= top_cur + pwfs_pkg::TOP_W'(1);
                  out_count        <= out_count - pwfs_pkg::OUT_W'(1);
                end
              end
              pwfs_pkg::OP_INIT: begin
                if (!pool_ready) begin
                  pool_ready <= 1'b1;
                  active     <= nw_sat;
                  cap        <= cap_sat;
                  out_count  <= '0;
                  for (int i = 0; i < pwfs_pkg::MAX_WORKERS; i++) begin
                    if (pwfs_pkg::ACT_W'(i) < nw_sat) begin
                      stack_top[i] <= cap_sat;
                    end
                  end
                  // Walk the memory unless there is nothing to place.
                  if (nw_sat != '0 && cap_sat != '0) begin
                    rsp_valid <= 1'b0;
                    fw        <= '0;
                    fi        <= '0;
                    off       <= '0;
                    state     <= S_FILL;
                  end
                end
              end
              pwfs_pkg::OP_DEINIT: begin
                if (pool_ready) begin
                  if (out_count != '0) begin
                    rsp.status <= pwfs_pkg::ST_OUTSTANDING;
                  end else begin
                    pool_ready <= 1'b0;
                    active     <= '0;
                    cap        <= '0;
                    for (int i = 0; i < pwfs_pkg::MAX_WORKERS; i++) begin
                      stack_top[i] <= '0;
                    end
                  end
                end
              end
              default: begin
                rsp.status <= pwfs_pkg::ST_OK;
              end
            endcase
          end
        end
        S_READ: begin
          rsp_valid        <= 1'b1;
          rsp.status       <= pwfs_pkg::ST_OK;
          rsp.alloc_handle <= rd_data;
          state            <= S_IDLE;
        end
        S_FILL: begin
          // One entry per cycle; offsets wrap to the handle width.
          off <= off + pwfs_pkg::HANDLE_W'(cfg.buf_size);
          if (last_i) begin
            fi  <= '0;
            off <= '0;
            if (last_w) begin
              rsp_valid        <= 1'b1;
              rsp.status       <= pwfs_pkg::ST_OK;
              rsp.alloc_handle <= '0;
              state            <= S_IDLE;
            end else begin
              fw <= fw + pwfs_pkg::WORKER_W'(1);
            end
          end else begin
            fi <= fi + pwfs_pkg::IDX_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/per_worker_free_buffer_stack.sv
// ----------------------------------------------------------------------------
// per_worker_free_buffer_stack
// Buffer manager with one LIFO free stack of buffer byte offsets per worker.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on req (cmd, worker, buf_handle) with req_valid/req_ready;
// every request gives exactly one response beat on rsp (status,
// alloc_handle) with rsp_valid/rsp_ready, in request order.
// Configuration registers (worker_count, buf_size, pool_count) are written
// through cfg_valid/cfg_index/cfg_data; cfg_ready is always high. Write them
// only while no request is in flight; init uses the values present then.
// A request passes a decode register and a two-entry command queue, then
// the execution unit. Free, deinit, a rejected command and init on a ready
// pool respond from idle; alloc adds a read state for the stack memory read.
// Init writes the stacks through the single memory write port, one entry a
// cycle: worker_count * pool_count entries after saturation. A request goes
// via decode, queue and response registers; a successful alloc also S_READ.
// Reset clears the fill levels and the pool state; the stack memory is not
// cleared and is only read at entries written by init or free.
// When the receiver stalls, the response is held in its register and the
// queue and decode register keep taking up to three more requests.
// ----------------------------------------------------------------------------
module per_worker_free_buffer_stack (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  pwfs_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output pwfs_pkg::rsp_t                      rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pwfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pwfs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pwfs_pkg::cfg_t     cfg;
  logic               f_valid;
  logic               f_ready;
  pwfs_pkg::op_item_t f_item;
  logic               q_valid;
  logic               q_ready;
  pwfs_pkg::op_item_t q_item;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.worker_count <= 6'd32;
      cfg.buf_size     <= 16'd2048;
      cfg.pool_count   <= 11'd1024;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwfs_pkg::REG_WORKER_COUNT: cfg.worker_count <= cfg_data[5:0];
        pwfs_pkg::REG_BUF_SIZE:     cfg.buf_size     <= cfg_data;
        pwfs_pkg::REG_POOL_COUNT:   cfg.pool_count   <= cfg_data[10:0];
        default: begin
          cfg.worker_count <= cfg.worker_count;
        end
      endcase
    end
  end

  pwfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op_item   (f_item)
  );

  pwfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  pwfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (q_valid),
    .op_ready  (q_ready),
    .op_item   (q_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
